FILE: sv/ial_pkg.sv
package ial_pkg;

    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_STEP        = 16;

    localparam int ACT_W   = 3;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 9;

    localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [STAT_W-1:0]       status;
        logic [CNT_W-1:0]        entry_count;
        logic [CNT_W-1:0]        capacity_now;
    } t_rsp;

endpackage

FILE: sv/ial_if.sv
interface ial_req_if import ial_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;

    modport source (output valid, action, position, item_value, input ready);
    modport sink   (input valid, action, position, item_value, output ready);
endinterface

interface ial_rsp_if import ial_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        entry_count;
    logic [CNT_W-1:0]        capacity_now;

    modport source (output valid, result_value, status, entry_count, capacity_now,
                    input ready);
    modport sink   (input valid, result_value, status, entry_count, capacity_now,
                    output ready);
endinterface

FILE: sv/indexed_array_list_top.sv
// Indexed array list: ordered list of signed 32-bit words in a single-port-write,
// single-port-read memory of MAX_ENTRIES words. One request is taken when the
// block is idle. A read passes through decode and a read-wait state; a write and
// every rejected request are settled in decode; insert and delete shift the tail
// of the list from the position by one place, one entry at a time; and search
// compares entries from the head up to the first match or the whole list on a
// miss. Each request then waits in a finish state until the output is free. The
// one memory read and one memory write per cycle set the pace of these walks.
// The result sits in an output register, so the next request can start while an
// earlier result still waits. Writing i_cfg_wdata with i_cfg_we empties the list
// and sets the step and capacity to it (0 as 1, above MAX_ENTRIES as MAX_ENTRIES).
module indexed_array_list_top import ial_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ial_req_if.sink          i_req,
    ial_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    logic r_out_valid;
    t_rsp r_out;
    logic eng_idle;
    logic eng_done;
    logic slot_free;
    t_rsp eng_rsp;

    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign i_req.ready = eng_idle;

    ial_engine #(.MAX_ENTRIES(MAX_ENTRIES)) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_req.valid),
        .i_action     (i_req.action),
        .i_position   (i_req.position),
        .i_item_value (i_req.item_value),
        .o_idle       (eng_idle),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_slot_free  (slot_free),
        .o_done       (eng_done),
        .o_rsp        (eng_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_out <= eng_rsp;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out.result_value;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.entry_count  = r_out.entry_count;
    assign o_rsp.capacity_now = r_out.capacity_now;

endmodule

FILE: sv/ial_mem.sv
module ial_mem import ial_pkg::*; #(
    parameter int DEPTH = DEF_MAX_ENTRIES,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [VAL_W-1:0] i_wd,
    input  logic [AW-1:0]    i_ra,
    output logic [VAL_W-1:0] o_rd
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;

endmodule

FILE: sv/ial_engine.sv
module ial_engine import ial_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ACT_W-1:0] i_action,
    input  logic [POS_W-1:0] i_position,
    input  logic [VAL_W-1:0] i_item_value,
    output logic             o_idle,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_slot_free,
    output logic             o_done,
    output t_rsp             o_rsp
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PX = CW + POS_W;
    localparam int RST_STEP = (DEF_STEP > MAX_ENTRIES) ? MAX_ENTRIES : DEF_STEP;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_SEARCH = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [ACT_W-1:0] r_act;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_cap, n_cap;
    logic [CW-1:0]    r_step;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [CW-1:0]    r_left, n_left;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_wa, n_wa;
    logic [VAL_W-1:0] r_res_val, n_res_val;
    logic [STAT_W-1:0] r_res_st, n_res_st;

    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [VAL_W-1:0] mem_wd;
    logic [AW-1:0]    mem_ra;
    logic [VAL_W-1:0] mem_rd;

    logic [PX-1:0]    pos_ext, cnt_ext;
    logic [AW-1:0]    pos_idx;
    logic [CW:0]      cap_grow;
    logic [CW+1:0]    shrink_lhs;
    logic [CW-1:0]    cnt_dec;
    logic [31:0]      cfg_ext;
    logic [CW-1:0]    cfg_step;
    logic             is_ins;

    ial_mem #(.DEPTH(MAX_ENTRIES)) u_mem (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_ra  (mem_ra),
        .o_rd  (mem_rd)
    );

    assign pos_ext  = PX'(r_pos);
    assign cnt_ext  = PX'(r_count);
    assign pos_idx  = AW'(pos_ext);
    assign cap_grow = (CW+1)'(r_cap) + (CW+1)'(r_step);
    assign cnt_dec  = r_count - CW'(1);
    assign shrink_lhs = (CW+2)'(cnt_dec) + ((CW+2)'(r_step) << 1);
    assign is_ins   = (r_act == ACT_INSERT);
    assign cfg_ext  = 32'(i_cfg_wdata);

    always_comb begin
        if (cfg_ext == 32'd0) begin
            cfg_step = CW'(1);
        end else if (cfg_ext > 32'(MAX_ENTRIES)) begin
            cfg_step = CW'(MAX_ENTRIES);
        end else begin
            cfg_step = CW'(cfg_ext);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cap     = r_cap;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_pend    = r_pend;
        n_wa      = r_wa;
        n_res_val = r_res_val;
        n_res_st  = r_res_st;
        mem_we    = 1'b0;
        mem_wa    = r_wa;
        mem_wd    = mem_rd;
        mem_ra    = r_ptr;
        o_done    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_val = '0;
                n_res_st  = ST_OK;
                n_pend    = 1'b0;
                n_state   = S_FIN;
                unique case (r_act)
                    ACT_READ: begin
                        if (pos_ext < cnt_ext) begin
                            mem_ra  = pos_idx;
                            n_state = S_RDWAIT;
                        end else begin
                            n_res_st = ST_BAD_POS;
                        end
                    end
                    ACT_WRITE: begin
                        if (pos_ext < cnt_ext) begin
                            mem_we = 1'b1;
                            mem_wa = pos_idx;
                            mem_wd = r_val;
                        end else begin
                            n_res_st = ST_BAD_POS;
                        end
                    end
                    ACT_INSERT: begin
                        if (pos_ext > cnt_ext) begin
                            n_res_st = ST_BAD_POS;
                        end else if (r_count >= r_cap &&
                                     32'(r_cap) >= 32'(MAX_ENTRIES)) begin
                            n_res_st = ST_FULL;
                        end else begin
                            if (r_count >= r_cap) begin
                                n_cap = (cap_grow > (CW+1)'(MAX_ENTRIES)) ?
                                        CW'(MAX_ENTRIES) : CW'(cap_grow);
                            end
                            n_left  = CW'(cnt_ext - pos_ext);
                            n_ptr   = AW'(cnt_ext - PX'(1));
                            n_state = S_SHIFT;
                        end
                    end
                    ACT_DELETE: begin
                        if (pos_ext >= cnt_ext) begin
                            n_res_st = ST_BAD_POS;
                        end else begin
                            n_left  = CW'(cnt_ext - pos_ext - PX'(1));
                            n_ptr   = AW'(pos_ext + PX'(1));
                            n_state = S_SHIFT;
                        end
                    end
                    ACT_SEARCH: begin
                        n_left  = r_count;
                        n_ptr   = '0;
                        n_state = S_SEARCH;
                    end
                    default: begin
                        n_res_st = ST_BAD_POS;
                    end
                endcase
            end
            S_RDWAIT: begin
                n_res_val = mem_rd;
                n_state   = S_FIN;
            end
            S_SHIFT: begin
                // move one entry per cycle: read ahead, write the previous read back
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_wa;
                    mem_wd = mem_rd;
                end
                if (r_left != '0) begin
                    mem_ra = r_ptr;
                    n_pend = 1'b1;
                    n_wa   = is_ins ? AW'(r_ptr + AW'(1)) : AW'(r_ptr - AW'(1));
                    n_ptr  = is_ins ? AW'(r_ptr - AW'(1)) : AW'(r_ptr + AW'(1));
                    n_left = r_left - CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (is_ins) begin
                            mem_we  = 1'b1;
                            mem_wa  = pos_idx;
                            mem_wd  = r_val;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_count = cnt_dec;
                            if (shrink_lhs <= (CW+2)'(r_cap)) begin
                                n_cap = r_cap - r_step;
                            end
                        end
                        n_state = S_FIN;
                    end
                end
            end
            S_SEARCH: begin
                if (r_pend && mem_rd == r_val) begin
                    n_res_val = 32'(r_wa);
                    n_res_st  = ST_OK;
                    n_pend    = 1'b0;
                    n_state   = S_FIN;
                end else if (r_left != '0) begin
                    mem_ra = r_ptr;
                    n_pend = 1'b1;
                    n_wa   = r_ptr;
                    n_ptr  = AW'(r_ptr + AW'(1));
                    n_left = r_left - CW'(1);
                end else begin
                    n_res_val = '1;
                    n_res_st  = ST_NOT_FOUND;
                    n_pend    = 1'b0;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (i_slot_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap   <= CW'(RST_STEP);
            r_step  <= CW'(RST_STEP);
            r_pend  <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_left  <= n_left;
            if (i_cfg_we) begin
                r_step  <= cfg_step;
                r_cap   <= cfg_step;
                r_count <= '0;
            end else begin
                r_count <= n_count;
                r_cap   <= n_cap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_wa      <= n_wa;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        if (r_state == S_IDLE && i_start) begin
            r_act <= i_action;
            r_pos <= i_position;
            r_val <= i_item_value;
        end
    end

    assign o_idle = (r_state == S_IDLE);

    assign o_rsp.result_value = r_res_val;
    assign o_rsp.status       = r_res_st;
    assign o_rsp.entry_count  = CNT_W'(r_count);
    assign o_rsp.capacity_now = CNT_W'(r_cap);

    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("entry count above capacity");

    a_cap_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cap) <= 32'(MAX_ENTRIES) && r_cap != '0)
        else $error("capacity out of range");

    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SHIFT || r_state == S_SEARCH))
        else $error("read pending outside a walk");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == S_IDLE && !r_pend))
        else $error("engine not idle after result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SHIFT && !$past(i_cfg_we)) |->
        ($stable(r_count) || $past(r_state) == S_SHIFT))
        else $error("count changed outside insert or delete");

endmodule
